// File: hw/rtl/lus_pkg.sv
// Package with the constants and control types of the longest unique substring block.
`timescale 1ns / 1ps
`default_nettype none

package lus_pkg;

   localparam int unsigned ALPHABET_SIZE = 256;
   localparam int unsigned POSITION_BITS = 16;

   localparam int unsigned CHAR_BITS  = 8;
   localparam int unsigned SYM_BITS   = $clog2(ALPHABET_SIZE);
   localparam int unsigned RING_DEPTH = 256;
   localparam int unsigned RING_BITS  = $clog2(RING_DEPTH);
   localparam int unsigned LEN_BITS   = 9;
   localparam int unsigned START_BITS = 16;

   localparam logic [POSITION_BITS:0] BYTE_POS_LIMIT = {1'b1, {POSITION_BITS{1'b0}}};
   localparam logic [POSITION_BITS-1:0] START_MAX = {POSITION_BITS{1'b1}};

   typedef struct packed {
      logic accept;
      logic push_new;
      logic pop;
      logic clear;
      logic drop;
      logic init_clear;
   } cmd_type;

   typedef struct packed {
      logic seen_hit;
      logic gone_match;
      logic last;
      logic drain_last;
      logic init_last;
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/lus_if.sv
// Valid/ready channel interfaces for the string bytes and the results.
`timescale 1ns / 1ps
`default_nettype none

interface lus_req_if;
   logic                          valid;
   logic                          ready;
   logic [lus_pkg::CHAR_BITS-1:0] next_char;
   logic                          final_char;

   modport source (output valid, output next_char, output final_char, input ready);
   modport sink (input valid, input next_char, input final_char, output ready);
endinterface

interface lus_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lus_pkg::LEN_BITS-1:0]   best_length;
   logic [lus_pkg::START_BITS-1:0] best_start;
   logic                           too_long;

   modport source (output valid, output best_length, output best_start, output too_long,
                   input ready);
   modport sink (input valid, input best_length, input best_start, input too_long,
                 output ready);
endinterface

`default_nettype wire

// File: hw/rtl/longest_unique_substring.sv
// Top level of the longest unique substring block: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none

// The block takes a string one byte per req transfer, with final_char set on the last byte,
// and returns one rsp transfer after that byte: the length and start position of the first
// longest run of distinct bytes, and too_long when the string ran past the position counter.
// After reset the block clears every entry of its seen map before it takes a byte.
// A byte not yet in the window needs only the lookup; for a byte already in the window the
// head walk then drops bytes from the window head up to and including the byte's earlier
// copy, reading the window ring one entry per cycle through its single read port. The result
// waits in the output until taken. After that transfer the block empties the final window
// one byte per cycle to clear the seen map, and takes the next string's first byte once
// that window, at most 256 bytes long, is empty.
module longest_unique_substring (
   input wire logic  clock,
   input wire logic  reset,
   lus_req_if.sink   req,
   lus_rsp_if.source rsp
);
   import lus_pkg::*;

   cmd_type    cmd;
   status_type status;

   lus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lus_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .next_char   (req.next_char),
      .final_char  (req.final_char),
      .cmd         (cmd),
      .status      (status),
      .best_length (rsp.best_length),
      .best_start  (rsp.best_start),
      .too_long    (rsp.too_long)
   );

   // Only one step of the datapath runs in any cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.push_new, cmd.pop, cmd.clear, cmd.drop, cmd.init_clear}))
      else $error("more than one datapath command in one cycle");

   // A result is never offered while a byte can be taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("input ready while a result is pending");

   // Every accepted byte is followed by a lookup cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (!req.ready && !rsp.valid))
      else $error("no lookup cycle after a byte transfer");

   // A string holds at least one byte, so the reported run is never empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.best_length != '0))
      else $error("empty run reported");

endmodule

`default_nettype wire

// File: hw/rtl/lus_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lus_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/lus_ctrl.sv
// Controller state machine that sequences the seen map clear, lookup, head walk, result transfer and window drain.
`timescale 1ns / 1ps
`default_nettype none

module lus_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire lus_pkg::status_type status,
   output lus_pkg::cmd_type         cmd
);
   import lus_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CHECK,
      S_WALK,
      S_RESP,
      S_DRAIN
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_INIT: begin
               if (status.init_last) begin
                  state_ff     <= S_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  state_ff     <= S_CHECK;
                  req_ready_ff <= 1'b0;
               end
            end
            S_CHECK: begin
               if (!status.seen_hit) begin
                  if (status.last) begin
                     state_ff     <= S_RESP;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff     <= S_IDLE;
                     req_ready_ff <= 1'b1;
                  end
               end else begin
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               if (status.gone_match) begin
                  if (status.last) begin
                     state_ff     <= S_RESP;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff     <= S_IDLE;
                     req_ready_ff <= 1'b1;
                  end
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= S_DRAIN;
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_DRAIN: begin
               if (status.drain_last) begin
                  state_ff     <= S_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= S_INIT;
               req_ready_ff <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd.accept     = (state_ff == S_IDLE) && req_valid;
      cmd.push_new   = (state_ff == S_CHECK) && !status.seen_hit;
      cmd.pop        = (state_ff == S_WALK);
      cmd.clear      = (state_ff == S_RESP) && rsp_ready;
      cmd.drop       = (state_ff == S_DRAIN);
      cmd.init_clear = (state_ff == S_INIT);
   end

endmodule

`default_nettype wire

// File: hw/rtl/lus_dp.sv
// Datapath with the seen map, window ring, window pointers and best-run registers.
`timescale 1ns / 1ps
`default_nettype none

module lus_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [lus_pkg::CHAR_BITS-1:0]  next_char,
   input  wire logic                           final_char,
   input  wire lus_pkg::cmd_type               cmd,
   output lus_pkg::status_type                 status,
   output logic      [lus_pkg::LEN_BITS-1:0]   best_length,
   output logic      [lus_pkg::START_BITS-1:0] best_start,
   output logic                                too_long
);
   import lus_pkg::*;

   logic [CHAR_BITS-1:0]     sym_ff, sym_in;
   logic                     last_ff, last_in;
   logic [RING_BITS-1:0]     head_ff, head_in;
   logic [LEN_BITS-1:0]      len_ff, len_in;
   logic [POSITION_BITS:0]   byte_pos_ff, byte_pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [LEN_BITS-1:0]      best_len_ff, best_len_in;
   logic [POSITION_BITS-1:0] best_start_ff, best_start_in;
   logic [SYM_BITS-1:0]      init_cnt_ff, init_cnt_in;

   logic                 ring_wr_en;
   logic [RING_BITS-1:0] ring_wr_addr;
   logic [CHAR_BITS-1:0] gone;
   logic                 gone_match;
   logic                 seen_wr_en;
   logic [SYM_BITS-1:0]  seen_wr_addr;
   logic                 seen_wr_data;
   logic                 seen_hit;

   // The tail slot sits one window length past the head and wraps around the ring.
   assign ring_wr_addr = head_ff + len_ff[RING_BITS-1:0];
   assign gone_match   = (gone == sym_ff);

   // The ring is read at the next head, so the oldest byte is ready in the cycle after.
   lus_ram #(
      .WIDTH (CHAR_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (sym_ff),
      .rd_addr (head_in),
      .rd_data (gone)
   );

   // The seen map is read at the incoming byte, so its bit is ready in the lookup cycle.
   lus_ram #(
      .WIDTH (1),
      .DEPTH (ALPHABET_SIZE)
   ) u_seen (
      .clock   (clock),
      .wr_en   (seen_wr_en),
      .wr_addr (seen_wr_addr),
      .wr_data (seen_wr_data),
      .rd_addr (sym_in[SYM_BITS-1:0]),
      .rd_data (seen_hit)
   );

   always_comb begin
      sym_in        = sym_ff;
      last_in       = last_ff;
      head_in       = head_ff;
      len_in        = len_ff;
      byte_pos_in   = byte_pos_ff;
      start_in      = start_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      init_cnt_in   = init_cnt_ff;
      ring_wr_en    = 1'b0;
      seen_wr_en    = 1'b0;
      seen_wr_addr  = sym_ff[SYM_BITS-1:0];
      seen_wr_data  = 1'b0;

      if (cmd.accept) begin
         sym_in  = CHAR_BITS'(32'(next_char) % ALPHABET_SIZE);
         last_in = final_char;
         if (byte_pos_ff <= BYTE_POS_LIMIT) begin
            byte_pos_in = byte_pos_ff + 1'b1;
         end
      end

      if (cmd.push_new) begin
         seen_wr_en   = 1'b1;
         seen_wr_data = 1'b1;
         ring_wr_en   = 1'b1;
         len_in       = len_ff + 1'b1;
         if (len_in > best_len_ff) begin
            best_len_in   = len_in;
            best_start_in = start_ff;
         end
      end

      if (cmd.pop) begin
         head_in = head_ff + 1'b1;
         if (start_ff != START_MAX) begin
            start_in = start_ff + 1'b1;
         end
         if (gone_match) begin
            // Dropping the earlier copy and appending the new one keeps the length.
            ring_wr_en = 1'b1;
         end else begin
            len_in       = len_ff - 1'b1;
            seen_wr_en   = 1'b1;
            seen_wr_addr = gone[SYM_BITS-1:0];
         end
      end

      // After a result transfer the window is emptied one byte per cycle, which leaves
      // the seen map cleared for the next string.
      if (cmd.drop) begin
         head_in      = head_ff + 1'b1;
         len_in       = len_ff - 1'b1;
         seen_wr_en   = 1'b1;
         seen_wr_addr = gone[SYM_BITS-1:0];
      end

      if (cmd.init_clear) begin
         seen_wr_en   = 1'b1;
         seen_wr_addr = init_cnt_ff;
         init_cnt_in  = init_cnt_ff + 1'b1;
      end

      if (cmd.clear) begin
         byte_pos_in   = '0;
         start_in      = '0;
         best_len_in   = '0;
         best_start_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         len_ff        <= '0;
         byte_pos_ff   <= '0;
         start_ff      <= '0;
         best_len_ff   <= '0;
         best_start_ff <= '0;
         init_cnt_ff   <= '0;
      end else begin
         head_ff       <= head_in;
         len_ff        <= len_in;
         byte_pos_ff   <= byte_pos_in;
         start_ff      <= start_in;
         best_len_ff   <= best_len_in;
         best_start_ff <= best_start_in;
         init_cnt_ff   <= init_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      last_ff <= last_in;
   end

   always_comb begin
      status.seen_hit   = seen_hit;
      status.gone_match = gone_match;
      status.last       = last_ff;
      status.drain_last = (len_ff == LEN_BITS'(1));
      status.init_last  = (init_cnt_ff == SYM_BITS'(ALPHABET_SIZE - 1));
   end

   assign best_length = best_len_ff;
   assign best_start  = START_BITS'(best_start_ff);
   assign too_long    = (byte_pos_ff > BYTE_POS_LIMIT);

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the longest unique substring block.
`timescale 1ns / 1ps

module tb;
   import lus_pkg::*;

   localparam int unsigned CYCLE_LIMIT           = 2_000_000;
   localparam int unsigned DRAIN_CYCLES          = 50;
   localparam int unsigned HOLD_CYCLES           = 400;
   localparam int unsigned SHORT_BYTES_PER_PHASE = 360;
   localparam int unsigned MAX_REPORTS           = 10;

   typedef logic [CHAR_BITS-1:0] char_type;

   typedef struct {
      logic [LEN_BITS-1:0]   length;
      logic [START_BITS-1:0] start;
      logic                  too_long;
   } window_type;

   // Tracks the sliding window of distinct bytes for the string in flight and queues the
   // best window of every finished string.
   class substring_scoreboard;
      bit                       in_window [ALPHABET_SIZE];
      char_type                 ring [RING_DEPTH];
      logic [RING_BITS-1:0]     head;
      logic [LEN_BITS-1:0]      win_len;
      logic [POSITION_BITS:0]   pos;
      logic [POSITION_BITS-1:0] win_start;
      logic [LEN_BITS-1:0]      best_len;
      logic [POSITION_BITS-1:0] best_start;
      window_type               expected_windows [$];
      int                       mismatches;
      int                       checked;

      function new();
         clear_string();
         mismatches = 0;
         checked = 0;
      endfunction

      function void clear_string();
         foreach (in_window[i]) in_window[i] = 1'b0;
         head = '0;
         win_len = '0;
         pos = '0;
         win_start = '0;
         best_len = '0;
         best_start = '0;
      endfunction

      function void append(logic [SYM_BITS-1:0] sym);
         logic [RING_BITS-1:0] slot;
         slot = head + win_len[RING_BITS-1:0];
         ring[slot] = char_type'(sym);
         win_len++;
      endfunction

      function void note_byte(char_type ch, logic fin);
         logic [SYM_BITS-1:0] sym;
         char_type            gone;
         int                  guard;
         bit                  found;
         window_type          w;
         sym = SYM_BITS'(ch % ALPHABET_SIZE);
         if (pos <= BYTE_POS_LIMIT) pos++;
         if (!in_window[sym]) begin
            in_window[sym] = 1'b1;
            append(sym);
            // Only a strictly longer window replaces the best one.
            if (win_len > best_len) begin
               best_len = win_len;
               best_start = win_start;
            end
         end else begin
            guard = win_len;
            found = 1'b0;
            while (guard > 0 && !found) begin
               gone = ring[head];
               guard--;
               head++;
               win_len--;
               if (win_start < START_MAX) win_start++;
               if (gone == char_type'(sym)) found = 1'b1;
               else in_window[gone] = 1'b0;
            end
            if (win_len < RING_DEPTH) append(sym);
         end
         if (fin) begin
            w.length = best_len;
            w.start = best_start[START_BITS-1:0];
            w.too_long = (pos > BYTE_POS_LIMIT);
            expected_windows.push_back(w);
            clear_string();
         end
      endfunction

      function void check_result(logic [LEN_BITS-1:0] length, logic [START_BITS-1:0] start,
                                 logic too_long);
         window_type w;
         if (expected_windows.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result length=%0d start=%0d too_long=%0b",
                        $realtime, length, start, too_long);
            return;
         end
         w = expected_windows.pop_front();
         checked++;
         if (length !== w.length || start !== w.start || too_long !== w.too_long) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result mismatch: length %0d/%0d start %0d/%0d too_long %0b/%0b %s",
                        $realtime, w.length, length, w.start, start, w.too_long, too_long,
                        "(expected/actual)");
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_phase = 0;
   bit   hold_now = 1'b0;
   int   bytes_sent = 0;
   int   strings_sent = 0;

   substring_scoreboard sb = new();

   lus_req_if req_ch ();
   lus_rsp_if rsp_ch ();

   longest_unique_substring dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Run exceeded %0d cycles.", CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Result side: checks each transfer and decides ready for the next edge.
   initial begin : result_side
      int hold_count;
      int stall_pct;
      hold_count = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.best_length, rsp_ch.best_start, rsp_ch.too_long);
         stall_pct = (idle_phase == 0) ? 64 : (idle_phase == 1) ? 19 : 0;
         if (hold_now && hold_count < HOLD_CYCLES) begin
            rsp_ch.ready <= 1'b0;
            hold_count++;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic send_byte(char_type ch, logic fin);
      int gap_pct;
      gap_pct = (idle_phase == 0) ? 19 : (idle_phase == 1) ? 64 : 0;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.next_char <= ch;
      req_ch.final_char <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_byte(ch, fin);
      bytes_sent++;
   endtask

   task automatic send_string(char_type s [$]);
      foreach (s[i]) send_byte(s[i], i == s.size() - 1);
      strings_sent++;
   endtask

   initial begin : stimulus
      char_type str [$];
      char_type tmp;
      int       phase_start;
      int       len;
      int       style;
      int       base;
      int       span;
      int       j;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.next_char <= '0;
      req_ch.final_char <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 3; p++) begin
         idle_phase = p;
         // The long output stall starts with the last phase.
         if (p == 2) hold_now = 1'b1;
         if (p == 0) begin
            str = '{8'h00};
            send_string(str);
            str = '{8'hFF};
            send_string(str);
            str = '{8'h00, 8'h00};
            send_string(str);
            // A later window of equal length must not replace the first one.
            str = '{8'h41, 8'h42, 8'h43, 8'h41, 8'h42, 8'h43};
            send_string(str);
            str = '{8'h05, 8'h06, 8'h05, 8'h07, 8'h08};
            send_string(str);
            str = '{8'h80, 8'h7F, 8'hFF, 8'h00, 8'h80};
            send_string(str);
         end

         phase_start = bytes_sent;
         while (bytes_sent - phase_start < SHORT_BYTES_PER_PHASE) begin
            len = $urandom_range(1, 40);
            style = $urandom_range(0, 2);
            base = $urandom_range(0, 255);
            span = $urandom_range(1, 12);
            str.delete();
            for (int k = 0; k < len; k++) begin
               case (style)
                  0: str.push_back(char_type'($urandom_range(0, 255)));
                  1: str.push_back(char_type'(base + $urandom_range(0, span)));
                  default: str.push_back($urandom_range(0, 1) ? char_type'(base)
                                                              : char_type'(base) ^ 8'hFF);
               endcase
            end
            send_string(str);
         end

         // A shuffled full alphabet, with a few random bytes around it.
         str.delete();
         for (int k = 0; k < 256; k++) str.push_back(char_type'(k));
         for (int k = 255; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = str[k];
            str[k] = str[j];
            str[j] = tmp;
         end
         repeat ($urandom_range(0, 3)) str.push_front(char_type'($urandom_range(0, 255)));
         repeat ($urandom_range(0, 2)) str.push_back(char_type'($urandom_range(0, 255)));
         send_string(str);

         req_ch.valid <= 1'b0;
         while (sb.expected_windows.size() != 0) @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d strings (%0d bytes) under three handshake mixes and a long output stall.",
               strings_sent, bytes_sent);
      $display("Strings covered ties, repeated bytes and full-alphabet windows; %0d results %s",
               sb.checked, "checked.");
      if (sb.mismatches == 0 && sb.expected_windows.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches.", sb.mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/lus_pkg.sv
hw/rtl/lus_if.sv
hw/rtl/lus_ram.sv
hw/rtl/lus_ctrl.sv
hw/rtl/lus_dp.sv
hw/rtl/longest_unique_substring.sv
test/tb.sv
